// ===== rtl/websocket_frame_header_parser_macros.svh =====
// Assertion macros for the WebSocket frame header parser.
// Included by the top level; no other dependencies.
`ifndef WEBSOCKET_FRAME_HEADER_PARSER_MACROS_SVH
`define WEBSOCKET_FRAME_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WSFHP_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("wsfhp same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define WSFHP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("wsfhp next-cycle check failed");

`endif

// ===== rtl/wsfhp_pkg.sv =====
// Types, constants and helper functions for the WebSocket frame header parser.
// No dependencies; used by every module of the block.
package wsfhp_pkg;

  localparam logic [7:0] FIN_MASK    = 8'h80;
  localparam logic [7:0] RSV_MASK    = 8'h70;
  localparam logic [7:0] OPCODE_MASK = 8'h0f;
  localparam logic [7:0] LEN_MASK    = 8'h7f;

  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;

  localparam logic [3:0] BASE_HDR_BYTES = 4'd2;
  localparam logic [3:0] KEY_BYTES      = 4'd4;

  typedef struct packed {
    logic [7:0] hdr_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  opcode;
    logic        masked;
    logic [31:0] payload_len;
    logic [31:0] mask_key;
    logic [3:0]  header_len;
    logic [32:0] frame_len;
    logic        status;
  } out_item_t;

  // Control between the parser and the top level.
  typedef struct packed {
    logic emit;
    logic active;
  } parse_ctl_t;

  function automatic logic [3:0] ext_bytes(input logic [6:0] code);
    logic [3:0] n;
    n = 4'd0;
    if (code == LEN_CODE_64) begin
      n = 4'd8;
    end else if (code == LEN_CODE_16) begin
      n = 4'd2;
    end
    return n;
  endfunction

  function automatic logic [3:0] hdr_bytes(input logic [6:0] code, input logic mask);
    return BASE_HDR_BYTES + ext_bytes(code) + (mask ? KEY_BYTES : 4'd0);
  endfunction

endpackage

// ===== rtl/wsfhp_parser.sv =====
// Header parse state and result formation for one registered header byte.
// Depends on wsfhp_pkg.
module wsfhp_parser import wsfhp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_vld,
  input  in_item_t   item,
  input  logic       step,
  output parse_ctl_t ctl,
  output out_item_t  result
);

  logic [3:0]  pos_r,   pos_nxt;
  logic        active_r, active_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [6:0]  code_r,  code_nxt;
  logic        mask_r,  mask_nxt;
  logic [31:0] lo_r,    lo_nxt;
  logic        hinz_r,  hinz_nxt;
  logic [31:0] key_r,   key_nxt;
  logic        emit;
  logic [3:0]  hlen;
  logic        status;
  logic [31:0] plen;
  logic [7:0]  b;

  assign b = item.hdr_byte;

  always_comb begin
    pos_nxt    = pos_r;
    active_nxt = active_r;
    first_nxt  = first_r;
    code_nxt   = code_r;
    mask_nxt   = mask_r;
    lo_nxt     = lo_r;
    hinz_nxt   = hinz_r;
    key_nxt    = key_r;
    emit       = 1'b0;
    if (item_vld) begin
      if (item.frame_start) begin
        first_nxt  = b;
        pos_nxt    = 4'd1;
        active_nxt = 1'b1;
        code_nxt   = '0;
        mask_nxt   = 1'b0;
        lo_nxt     = '0;
        hinz_nxt   = 1'b0;
        key_nxt    = '0;
      end else if (active_r) begin
        if (pos_r == 4'd1) begin
          mask_nxt = b[7];
          code_nxt = b[6:0];
          lo_nxt   = (b[6:0] < LEN_CODE_16) ? {25'd0, b[6:0]} : 32'd0;
          pos_nxt  = 4'd2;
        end else begin
          if (pos_r < BASE_HDR_BYTES + ext_bytes(code_r)) begin
            // Only the low word of the length is kept; any nonzero byte that
            // leaves it is remembered for the range check.
            lo_nxt   = {lo_r[23:0], b};
            hinz_nxt = hinz_r | (lo_r[31:24] != 8'd0);
          end else begin
            key_nxt = {key_r[23:0], b};
          end
          pos_nxt = pos_r + 4'd1;
        end
        if (pos_nxt >= hdr_bytes(code_nxt, mask_nxt)) begin
          emit       = 1'b1;
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      active_r <= 1'b0;
      first_r  <= '0;
      code_r   <= '0;
      mask_r   <= 1'b0;
      lo_r     <= '0;
      hinz_r   <= 1'b0;
      key_r    <= '0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      active_r <= active_nxt;
      first_r  <= first_nxt;
      code_r   <= code_nxt;
      mask_r   <= mask_nxt;
      lo_r     <= lo_nxt;
      hinz_r   <= hinz_nxt;
      key_r    <= key_nxt;
    end
  end

  assign hlen   = hdr_bytes(code_nxt, mask_nxt);
  assign status = (code_nxt == LEN_CODE_64) && hinz_nxt;
  assign plen   = status ? 32'd0 : lo_nxt;

  always_comb begin
    result.fin         = |(first_nxt & FIN_MASK);
    result.rsv         = 3'((first_nxt & RSV_MASK) >> 4);
    result.opcode      = 4'(first_nxt & OPCODE_MASK);
    result.masked      = mask_nxt;
    result.payload_len = plen;
    result.mask_key    = mask_nxt ? key_nxt : 32'd0;
    result.header_len  = hlen;
    result.frame_len   = {29'd0, hlen} + {1'b0, plen};
    result.status      = status;
  end

  assign ctl.emit   = emit;
  assign ctl.active = active_r;

endmodule

// ===== rtl/wsfhp_out_reg.sv =====
// Result register holding one finished header request until it is taken.
// Depends on wsfhp_pkg.
module wsfhp_out_reg import wsfhp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_data,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      vld_r;
  out_item_t data_r;

  assign space = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

// ===== rtl/websocket_frame_header_parser.sv =====
// WebSocket frame header parser, one header byte per request, one result per header.
// Path: the last header byte passes the input register, then the result register,
// and may wait in the input register while the result register is full.
// Throughput: one byte per cycle; the input register stalls only when a header
// completes while the result register is still full and not being taken.
// Reset: synchronous active-low rst_n; the parser waits for a frame start.
`include "websocket_frame_header_parser_macros.svh"

module websocket_frame_header_parser import wsfhp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic       in_vld_r;
  in_item_t   in_data_r;
  logic       proceed;
  logic       step;
  logic       space;
  parse_ctl_t ctl;
  out_item_t  result;

  // The registered byte moves on unless it would finish a header that has nowhere to go.
  assign proceed  = !ctl.emit || space;
  assign step     = in_vld_r && proceed;
  assign in_ready = !in_vld_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  wsfhp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (in_vld_r),
    .item     (in_data_r),
    .step     (step),
    .ctl      (ctl),
    .result   (result)
  );

  wsfhp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && ctl.emit),
    .load_data (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `WSFHP_ASSERT_NEXT(a_emit_loads, clk, rst_n, step && ctl.emit, out_valid)
  `WSFHP_ASSERT_NOW(a_hlen_range, clk, rst_n, out_valid,
                    out_data.header_len >= 4'd2 && out_data.header_len <= 4'd14 &&
                    !out_data.header_len[0])
  `WSFHP_ASSERT_NOW(a_err_zero_len, clk, rst_n, out_valid && out_data.status,
                    out_data.payload_len == 32'd0 &&
                    out_data.frame_len == {29'd0, out_data.header_len})
  `WSFHP_ASSERT_NOW(a_unmasked_key, clk, rst_n, out_valid && !out_data.masked,
                    out_data.mask_key == 32'd0)

endmodule
